[design/ssr_pkg.sv]
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types, register indexes and helpers for the stream search-and-replace
// block.
// ----------------------------------------------------------------------------
package ssr_pkg;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } reg_index_t;

    // what a queued descriptor emits
    typedef enum logic {
        DESC_WINDOW  = 1'b0,
        DESC_REPLACE = 1'b1
    } desc_kind_t;

    // control part of one output descriptor
    typedef struct packed {
        desc_kind_t  kind;
        logic        last;
        logic [15:0] total;
    } desc_ctl_t;

    localparam int unsigned CTL_W      = $bits(desc_ctl_t);
    localparam logic [15:0] COUNT_SAT  = 16'hFFFF;
    localparam int unsigned WORD_BYTES = 8;

    // byte i of a 64-bit word, zero beyond the word
    function automatic logic [7:0] byte_of(input logic [63:0] word, input logic [5:0] i);
        logic [7:0] b;
        b = 8'd0;
        if (i < 6'(WORD_BYTES))
        begin
            b = word[{i[2:0], 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

[design/stream_search_replace.sv]
// ----------------------------------------------------------------------------
// stream_search_replace
// Streaming byte search-and-replace with a configurable pattern and
// replacement, built around a shifting row of window cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the source string, one byte per transfer, s_tlast on its
//   final byte. m_* carries the rewritten string, one byte per transfer;
//   m_tuser low marks a bare end marker, m_tlast marks the last result of a
//   string and then m_tdata[23:8] holds the replacement count (saturating).
//   The APB port sets pattern, lengths and replacement; write it only while
//   no results are outstanding.
//   The window accepts one byte per cycle while s_tready is high; each byte
//   queues at most one descriptor, and the output sequencer sends one result
//   per cycle while m_tready takes them, so a match sends up to REPLACE_MAX
//   bytes and an unmatched string end up to PATTERN_MAX. s_tready drops when
//   the 4-entry descriptor queue is full; a stall on m_tready holds the
//   output register and fills the queue. Reset clears the window fill, the
//   count, the queue and the output valid flag, and sets the registers to
//   pattern length 1, all else zero.
// ----------------------------------------------------------------------------
module stream_search_replace
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // source stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] replace_count
    output logic        m_tlast,   // final_item
    output logic        m_tuser,   // [0] byte_present
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    import ssr_pkg::*;

    localparam int MAXR    = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
    localparam int CW      = $clog2(MAXR + 1);
    localparam int SW      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PW      = $clog2(PATTERN_MAX + 1);
    localparam int QW      = CTL_W + SW + CW + 8 * PATTERN_MAX;
    localparam int Q_DEPTH = 4;

    // configuration registers
    logic [63:0] pattern_bytes_reg;
    logic [3:0]  pattern_length_reg;
    logic [63:0] replacement_bytes_reg;
    logic [3:0]  replacement_length_reg;
    reg_index_t  reg_sel;
    logic        cfg_write;

    // window control
    logic [PW-1:0] fill_reg;
    logic [PW-1:0] fill_next;
    logic [15:0]   total_reg;
    logic [15:0]   total_next;
    logic [PW-1:0] plen;
    logic [CW-1:0] rlen;
    logic [PW-1:0] kept;
    logic [PW-1:0] fill_new;
    logic          cmp;
    logic          hit;
    logic          accept;

    // cells
    logic [7:0]             cell_q   [PATTERN_MAX];
    logic [7:0]             cell_d   [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_ok;

    // descriptors
    desc_ctl_t              new_ctl;
    logic [SW-1:0]          new_start;
    logic [CW-1:0]          new_count;
    logic [8*PATTERN_MAX-1:0] new_bytes;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_empty;
    logic                   q_full;
    logic [QW-1:0]          q_head;
    desc_ctl_t              h_ctl;
    logic [SW-1:0]          h_start;
    logic [CW-1:0]          h_count;
    logic [8*PATTERN_MAX-1:0] h_bytes;

    // apb write and read
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= 64'd0;
            pattern_length_reg     <= 4'd1;
            replacement_bytes_reg  <= 64'd0;
            replacement_length_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_PATTERN_BYTES:      pattern_bytes_reg      <= pwdata;
                REG_PATTERN_LENGTH:     pattern_length_reg     <= pwdata[3:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= pwdata;
                REG_REPLACEMENT_LENGTH: replacement_length_reg <= pwdata[3:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_PATTERN_BYTES:      prdata = pattern_bytes_reg;
            REG_PATTERN_LENGTH:     prdata = {60'd0, pattern_length_reg};
            REG_REPLACEMENT_BYTES:  prdata = replacement_bytes_reg;
            REG_REPLACEMENT_LENGTH: prdata = {60'd0, replacement_length_reg};
            default:                prdata = 64'd0;
        endcase
    end

    // clamp the configured lengths
    always_comb
    begin
        if (pattern_length_reg == 4'd0)
        begin
            plen = PW'(1);
        end
        else if (int'(pattern_length_reg) > PATTERN_MAX)
        begin
            plen = PW'(PATTERN_MAX);
        end
        else
        begin
            plen = PW'(pattern_length_reg);
        end
        if (int'(replacement_length_reg) > REPLACE_MAX)
        begin
            rlen = CW'(REPLACE_MAX);
        end
        else
        begin
            rlen = CW'(replacement_length_reg);
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // row of window cells, newest byte in cell 0
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [7:0] nb_in;
        logic [5:0] pat_idx;

        if (k == 0)
        begin : g_head
            assign nb_in = s_tdata;
        end
        else
        begin : g_link
            assign nb_in = cell_q[k-1];
        end

        // cell k lines up with pattern byte plen-1-k
        assign pat_idx = 6'(plen) - 6'(k) - 6'd1;

        ssr_cell u_cell
        (
            .clk          (clk),
            .shift_en     (accept),
            .byte_in      (nb_in),
            .pattern_byte (byte_of(pattern_bytes_reg, pat_idx)),
            .byte_q       (cell_q[k]),
            .byte_d       (cell_d[k]),
            .match        (cell_ok[k])
        );

        assign new_bytes[8*k +: 8] = cell_d[k];
    end

    // fill tracking, compare and descriptor build
    always_comb
    begin
        kept      = (fill_reg >= plen) ? plen - 1'b1 : fill_reg;
        fill_new  = kept + 1'b1;
        cmp       = (fill_new == plen);
        hit       = cmp;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if ((PW'(k) < plen) && !cell_ok[k])
            begin
                hit = 1'b0;
            end
        end
        total_next = total_reg;
        if (hit && (total_reg != COUNT_SAT))
        begin
            total_next = total_reg + 16'd1;
        end
        new_ctl.last  = s_tlast;
        new_ctl.total = total_next;
        if (hit)
        begin
            new_ctl.kind = DESC_REPLACE;
            new_start    = '0;
            new_count    = rlen;
            fill_next    = '0;
        end
        else if (cmp)
        begin
            new_ctl.kind = DESC_WINDOW;
            new_start    = SW'(plen - 1'b1);
            new_count    = s_tlast ? CW'(plen) : CW'(1);
            fill_next    = plen - 1'b1;
        end
        else
        begin
            new_ctl.kind = DESC_WINDOW;
            new_start    = SW'(fill_new - 1'b1);
            new_count    = s_tlast ? CW'(fill_new) : '0;
            fill_next    = fill_new;
        end
        if (s_tlast)
        begin
            fill_next  = '0;
            total_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= 16'd0;
        end
        else if (accept)
        begin
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
    end

    assign q_push = accept && ((new_count != '0) || s_tlast);

    // descriptor queue
    ssr_queue
    #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({new_ctl, new_start, new_count, new_bytes}),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {h_ctl, h_start, h_count, h_bytes} = q_head;

    // output sequencer
    ssr_emit
    #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    )
    u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (!q_empty),
        .desc_ctl   (h_ctl),
        .desc_start (h_start),
        .desc_count (h_count),
        .desc_bytes (h_bytes),
        .repl_word  (replacement_bytes_reg),
        .desc_pop   (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // a string end leaves an empty window and a cleared count
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> (fill_reg == '0) && (total_reg == 16'd0))
        else $error("window or count not cleared after string end");

    // the window never holds more than the longest pattern less one byte
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < PW'(PATTERN_MAX))
        else $error("window fill beyond the longest pattern");

    // a bare end marker is always the final result
    a_bare_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("bare end marker without final mark");

    // the count travels only with the final result
    a_count_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[23:8] == 16'd0)
        else $error("replacement count on a non-final result");
`endif

endmodule

[design/ssr_cell.sv]
// ----------------------------------------------------------------------------
// ssr_cell
// One window cell: holds a text byte, passes it to the next cell on every
// transfer and compares its incoming byte against its pattern byte.
// ----------------------------------------------------------------------------
module ssr_cell
(
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] byte_in,
    input  logic [7:0] pattern_byte,
    output logic [7:0] byte_q,
    output logic [7:0] byte_d,
    output logic       match
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // take the neighbor's byte on a transfer
    always_comb
    begin
        byte_next = shift_en ? byte_in : byte_reg;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;
    assign byte_d = byte_next;
    assign match  = (byte_next == pattern_byte);

endmodule

[design/ssr_queue.sv]
// ----------------------------------------------------------------------------
// ssr_queue
// Small register queue of output descriptors between the window and the
// output sequencer.
// ----------------------------------------------------------------------------
module ssr_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset on payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = data_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

endmodule

[design/ssr_emit.sv]
// ----------------------------------------------------------------------------
// ssr_emit
// Output sequencer: walks the head descriptor one result per cycle unless
// m_tready stalls it, and drives the registered master-side stream.
// ----------------------------------------------------------------------------
module ssr_emit
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8,
    localparam int MAXR = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX,
    localparam int CW   = $clog2(MAXR + 1),
    localparam int SW   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        desc_valid,
    input  ssr_pkg::desc_ctl_t          desc_ctl,
    input  logic [SW-1:0]               desc_start,
    input  logic [CW-1:0]               desc_count,
    input  logic [8*PATTERN_MAX-1:0]    desc_bytes,
    input  logic [63:0]                 repl_word,
    output logic                        desc_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    import ssr_pkg::*;

    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          valid_reg;
    logic          valid_next;
    logic [7:0]    byte_reg;
    logic [7:0]    byte_next;
    logic          present_reg;
    logic          present_next;
    logic          final_reg;
    logic          final_next;
    logic [15:0]   total_reg;
    logic [15:0]   total_next;

    logic          step;
    logic          at_end;
    logic [CW-1:0] last_idx;
    logic [SW-1:0] win_sel;
    logic [7:0]    win_byte;
    logic [7:0]    rep_byte;

    // pick the result byte for the current index
    always_comb
    begin
        last_idx = (desc_count == '0) ? '0 : desc_count - 1'b1;
        at_end   = (idx_reg == last_idx);
        win_sel  = desc_start - SW'(idx_reg);
        win_byte = desc_bytes[8*win_sel +: 8];
        rep_byte = byte_of(repl_word, 6'(idx_reg));
    end

    // output register loads when empty or taken
    always_comb
    begin
        step         = desc_valid && (!valid_reg || m_tready);
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        present_next = present_reg;
        final_next   = final_reg;
        total_next   = total_reg;
        if (step)
        begin
            valid_next   = 1'b1;
            present_next = (desc_count != '0);
            final_next   = desc_ctl.last && at_end;
            total_next   = (desc_ctl.last && at_end) ? desc_ctl.total : 16'd0;
            idx_next     = at_end ? '0 : idx_reg + 1'b1;
            if (desc_count == '0)
            begin
                byte_next = 8'd0;
            end
            else if (desc_ctl.kind == DESC_REPLACE)
            begin
                byte_next = rep_byte;
            end
            else
            begin
                byte_next = win_byte;
            end
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        present_reg <= present_next;
        final_reg   <= final_next;
        total_reg   <= total_next;
    end

    assign desc_pop = step && at_end;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {total_reg, byte_reg};
    assign m_tlast  = final_reg;
    assign m_tuser  = present_reg;

endmodule
